@@ rtl/chi_pkg.sv @@
`timescale 1ns / 1ps
package chi_pkg;

  localparam int KeyBits    = 16;
  localparam int TableSlots = 10;
  localparam int SlotBits   = 4;
  localparam int SqBits     = 2 * KeyBits;
  // Enough decimal digits for a squared key.
  localparam int SqDigits   = 10;
  localparam logic [SlotBits-1:0] NoLink = 4'd15;
  // Reciprocal of ten scaled by 2^(SqBits+3), exact for every SqBits-bit value.
  localparam logic [SqBits-1:0] RecipTen = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    HASH_DIV  = 2'd0,
    HASH_MID  = 2'd1,
    HASH_FOLD = 2'd2,
    HASH_MUL  = 2'd3
  } hash_mode_e;

  typedef enum logic [2:0] {
    ST_HOME      = 3'd0,
    ST_CHAINED   = 3'd1,
    ST_DISPLACED = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_BAD_KEY   = 3'd4,
    ST_READ_DONE = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } command_e;

  typedef struct packed {
    logic [0:0]  command;
    logic [15:0] key;
    logic [3:0]  slot_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] slot_key;
    logic [3:0]  slot_link;
    logic [0:0]  slot_used;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH_NEW,
    S_HASH_NEW_WAIT,
    S_PROBE,
    S_HASH_OLD,
    S_HASH_OLD_WAIT,
    S_DECIDE,
    S_WALK_TAIL,
    S_WALK_PRED,
    S_WRITE,
    S_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic hash_start;
    logic hash_sel_old;
    logic latch_home;
    logic latch_ohome;
    logic probe_step;
    logic walk_init_tail;
    logic walk_init_pred;
    logic walk_step;
    logic do_home;
    logic do_chain;
    logic do_displace;
    logic finish_bad;
    logic finish_overflow;
    logic finish_read;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_read;
    logic key_zero;
    logic hash_done;
    logic home_used;
    logic probe_done;
    logic probe_found;
    logic same_home;
    logic walk_done;
  } stat_t;

endpackage

@@ rtl/chi_hash.sv @@
`timescale 1ns / 1ps
// Multi-cycle home slot calculator. Decimal digits are peeled off one per
// cycle by multiplying with the reciprocal of ten.
module chi_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    mode_i,
  input  logic [chi_pkg::KeyBits-1:0]   key_i,
  output logic                          done_o,
  output logic [chi_pkg::SlotBits-1:0]  home_o
);
  import chi_pkg::*;

  typedef enum logic [1:0] {H_IDLE, H_SQUARE, H_COUNT, H_PICK} hstate_e;

  hstate_e           hst_q, hst_d;
  logic [SqBits-1:0] val_q, val_d, sq_q, sq_d;
  logic [4:0]        n_q, n_d, pos_q, pos_d;
  logic [SlotBits-1:0] acc_q, acc_d;
  logic              done_q, done_d;
  logic [2*SqBits-1:0] recip_prod;
  logic [SqBits-1:0] quot;
  logic [SlotBits-1:0] rem;
  logic [SlotBits:0]  acc_sum;

  // Quotient and remainder of the current value by ten.
  assign recip_prod = (2*SqBits)'(val_q) * (2*SqBits)'(RecipTen);
  assign quot    = SqBits'(recip_prod >> (SqBits + 3));
  assign rem     = SlotBits'(val_q - ((quot << 3) + (quot << 1)));
  assign acc_sum = {1'b0, acc_q} + {1'b0, rem};

  // Sequencer over digits.
  always_comb begin
    hst_d  = hst_q;
    val_d  = val_q;
    sq_d   = sq_q;
    n_d    = n_q;
    pos_d  = pos_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    case (hst_q)
      H_IDLE: begin
        if (start_i) begin
          acc_d = '0;
          n_d   = '0;
          case (hash_mode_e'(mode_i))
            HASH_DIV: begin
              val_d = SqBits'(key_i);
              hst_d = H_PICK;
            end
            HASH_MUL: begin
              val_d = SqBits'(key_i) << 2;
              hst_d = H_PICK;
            end
            HASH_FOLD: begin
              val_d = SqBits'(key_i);
              hst_d = H_COUNT;
            end
            default: begin
              val_d = SqBits'(key_i);
              hst_d = H_SQUARE;
            end
          endcase
        end
      end
      H_SQUARE: begin
        sq_d  = val_q * val_q;
        val_d = val_q * val_q;
        hst_d = H_COUNT;
      end
      H_COUNT: begin
        if (val_q == '0) begin
          if (hash_mode_e'(mode_i) == HASH_FOLD) begin
            done_d = 1'b1;
            hst_d  = H_IDLE;
          end else begin
            pos_d = n_q >> 1;
            val_d = sq_q;
            hst_d = H_PICK;
          end
        end else begin
          val_d = quot;
          n_d   = n_q + 5'd1;
          if (acc_sum >= 5'd10) acc_d = SlotBits'(acc_sum - 5'd10);
          else acc_d = SlotBits'(acc_sum);
        end
      end
      H_PICK: begin
        if (hash_mode_e'(mode_i) == HASH_MID && pos_q != '0) begin
          val_d = quot;
          pos_d = pos_q - 5'd1;
        end else begin
          acc_d  = rem;
          done_d = 1'b1;
          hst_d  = H_IDLE;
        end
      end
      default: hst_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q  <= H_IDLE;
      done_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      hst_q  <= hst_d;
      done_q <= done_d;
      pos_q  <= (hst_q == H_IDLE) ? '0 : pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    sq_q  <= sq_d;
    n_q   <= n_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign home_o = acc_q;

endmodule

@@ rtl/chi_datapath.sv @@
`timescale 1ns / 1ps
// Table storage, probing and chain walking registers.
module chi_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        mode_i,
  input  chi_pkg::in_item_t item_i,
  input  chi_pkg::ctrl_t    ctrl_i,
  output chi_pkg::stat_t    stat_o,
  output chi_pkg::out_item_t res_o
);
  import chi_pkg::*;

  logic [KeyBits-1:0]  key_store_q [TableSlots];
  logic [SlotBits-1:0] link_q [TableSlots];
  logic [TableSlots-1:0] used_q;

  in_item_t            item_q;
  logic [SlotBits-1:0] home_q, ohome_q, dest_q, cur_q;
  logic                found_q, walk_done_q, walk_pred_q;
  out_item_t           res_q, res_d;
  logic                res_en;
  logic                redirect;
  logic                hash_done;
  logic [SlotBits-1:0] hash_home;
  logic [KeyBits-1:0]  hash_key;
  logic [SlotBits-1:0] cur_link;

  assign hash_key = ctrl_i.hash_sel_old ? key_store_q[home_q] : item_q.key;
  // The displaced key takes the link of the home slot before the
  // predecessor search, so the free slot reads that link during the search.
  assign cur_link = (walk_pred_q && cur_q == dest_q) ? link_q[home_q] : link_q[cur_q];
  // The predecessor is redirected only when the search found it.
  assign redirect = walk_done_q && walk_pred_q && (cur_link == home_q);

  chi_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.hash_start),
    .mode_i  (mode_i),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  // Item, probe and walk registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) item_q <= item_i;
    if (ctrl_i.latch_home) begin
      home_q  <= hash_home;
      dest_q  <= hash_home;
      found_q <= 1'b0;
    end
    if (ctrl_i.latch_ohome) ohome_q <= hash_home;
    if (ctrl_i.probe_step && !found_q) begin
      if (dest_q == SlotBits'(TableSlots - 1)) begin
        dest_q <= SlotBits'(TableSlots);
      end else begin
        dest_q <= dest_q + 1'b1;
        if (!used_q[dest_q + 1'b1]) found_q <= 1'b1;
      end
    end
    if (ctrl_i.walk_init_tail) begin
      cur_q       <= home_q;
      walk_done_q <= 1'b0;
      walk_pred_q <= 1'b0;
    end
    if (ctrl_i.walk_init_pred) begin
      cur_q       <= ohome_q;
      walk_done_q <= 1'b0;
      walk_pred_q <= 1'b1;
    end
    if (ctrl_i.walk_step && !walk_done_q) begin
      if (cur_link >= SlotBits'(TableSlots) || (walk_pred_q && cur_link == home_q)) begin
        walk_done_q <= 1'b1;
      end else begin
        cur_q <= cur_link;
      end
    end
  end

  // Table storage; keys have no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_home) key_store_q[home_q] <= item_q.key;
    if (ctrl_i.do_chain) key_store_q[dest_q] <= item_q.key;
    if (ctrl_i.do_displace) begin
      key_store_q[dest_q] <= key_store_q[home_q];
      key_store_q[home_q] <= item_q.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < TableSlots; i++) link_q[i] <= NoLink;
    end else begin
      if (ctrl_i.do_home) begin
        used_q[home_q] <= 1'b1;
        link_q[home_q] <= NoLink;
      end
      if (ctrl_i.do_chain) begin
        used_q[dest_q] <= 1'b1;
        link_q[cur_q]  <= dest_q;
        link_q[dest_q] <= NoLink;
      end
      if (ctrl_i.do_displace) begin
        used_q[dest_q] <= 1'b1;
        link_q[dest_q] <= (redirect && cur_q == dest_q) ? dest_q : link_q[home_q];
        if (redirect && cur_q != dest_q) link_q[cur_q] <= dest_q;
        link_q[home_q] <= NoLink;
      end
    end
  end

  // Result of the finishing command.
  assign res_en = ctrl_i.do_home || ctrl_i.do_chain || ctrl_i.do_displace ||
                  ctrl_i.finish_bad || ctrl_i.finish_overflow || ctrl_i.finish_read;

  always_comb begin
    res_d           = '0;
    res_d.slot_link = NoLink;
    if (ctrl_i.do_home) begin
      res_d.status = ST_HOME;
      res_d.slot   = home_q;
    end else if (ctrl_i.do_chain) begin
      res_d.status = ST_CHAINED;
      res_d.slot   = dest_q;
    end else if (ctrl_i.do_displace) begin
      res_d.status = ST_DISPLACED;
      res_d.slot   = home_q;
    end else if (ctrl_i.finish_bad) begin
      res_d.status = ST_BAD_KEY;
    end else if (ctrl_i.finish_overflow) begin
      res_d.status = ST_OVERFLOW;
    end else begin
      res_d.status = ST_READ_DONE;
      res_d.slot   = item_q.slot_select;
      if (item_q.slot_select < SlotBits'(TableSlots) && used_q[item_q.slot_select]) begin
        res_d.slot_key  = key_store_q[item_q.slot_select];
        res_d.slot_link = link_q[item_q.slot_select];
        res_d.slot_used = 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (res_en) res_q <= res_d;
  end

  assign stat_o.is_read     = (item_q.command == CMD_READ);
  assign stat_o.key_zero    = (item_q.key == '0);
  assign stat_o.hash_done   = hash_done;
  assign stat_o.home_used   = used_q[home_q];
  assign stat_o.probe_done  = found_q || (dest_q >= SlotBits'(TableSlots));
  assign stat_o.probe_found = found_q;
  assign stat_o.same_home   = (ohome_q == home_q);
  assign stat_o.walk_done   = walk_done_q;
  assign res_o = res_q;

endmodule

@@ rtl/chi_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing of one command at a time.
module chi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  chi_pkg::stat_t stat_i,
  output chi_pkg::ctrl_t ctrl_o
);
  import chi_pkg::*;

  state_e      st_q, st_d;
  logic        chain_q, chain_d;
  logic [3:0]  steps_q, steps_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      chain_q <= 1'b0;
      steps_q <= '0;
    end else begin
      st_q    <= st_d;
      chain_q <= chain_d;
      steps_q <= steps_d;
    end
  end

  always_comb begin
    st_d     = st_q;
    chain_d  = chain_q;
    steps_d  = steps_q;
    ctrl_o   = '0;
    in_stall_o  = (st_q != S_IDLE);
    out_valid_o = (st_q == S_OUT);
    case (st_q)
      S_IDLE: if (in_valid_i) begin
        ctrl_o.load = 1'b1;
        st_d = S_HASH_NEW;
      end
      S_HASH_NEW: begin
        if (stat_i.is_read) begin
          ctrl_o.finish_read = 1'b1;
          st_d = S_OUT;
        end else if (stat_i.key_zero) begin
          ctrl_o.finish_bad = 1'b1;
          st_d = S_OUT;
        end else begin
          ctrl_o.hash_start = 1'b1;
          st_d = S_HASH_NEW_WAIT;
        end
      end
      S_HASH_NEW_WAIT: if (stat_i.hash_done) begin
        ctrl_o.latch_home = 1'b1;
        st_d = S_PROBE;
      end
      S_PROBE: begin
        if (!stat_i.home_used) begin
          ctrl_o.do_home = 1'b1;
          st_d = S_OUT;
        end else if (stat_i.probe_done) begin
          st_d = S_HASH_OLD;
        end else begin
          ctrl_o.probe_step = 1'b1;
        end
      end
      S_HASH_OLD: begin
        if (!stat_i.probe_found) begin
          ctrl_o.finish_overflow = 1'b1;
          st_d = S_OUT;
        end else begin
          ctrl_o.hash_start   = 1'b1;
          ctrl_o.hash_sel_old = 1'b1;
          st_d = S_HASH_OLD_WAIT;
        end
      end
      S_HASH_OLD_WAIT: begin
        ctrl_o.hash_sel_old = 1'b1;
        if (stat_i.hash_done) begin
          ctrl_o.latch_ohome = 1'b1;
          st_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        steps_d = '0;
        if (stat_i.same_home) begin
          ctrl_o.walk_init_tail = 1'b1;
          chain_d = 1'b1;
          st_d = S_WALK_TAIL;
        end else begin
          ctrl_o.walk_init_pred = 1'b1;
          chain_d = 1'b0;
          st_d = S_WALK_PRED;
        end
      end
      S_WALK_TAIL, S_WALK_PRED: begin
        if (stat_i.walk_done || steps_q == 4'(TableSlots)) begin
          st_d = S_WRITE;
        end else begin
          ctrl_o.walk_step = 1'b1;
          steps_d = steps_q + 4'd1;
        end
      end
      S_WRITE: begin
        if (chain_q) ctrl_o.do_chain = 1'b1;
        else ctrl_o.do_displace = 1'b1;
        st_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while a result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.do_home, ctrl_o.do_chain, ctrl_o.do_displace}))
    else $error("two table writes at once");

endmodule

@@ rtl/chained_hash_insert_with_replacement.sv @@
`timescale 1ns / 1ps
// Ten-slot hash table with chaining and replacement.
// The input channel (in_valid_i / in_stall_o) carries a command: insert a
// key, or read one slot. A transfer takes place on a clock edge with valid
// high and stall low. Each command gives exactly one result on the output
// channel (out_valid_o / out_stall_i), held steady while the receiver stalls;
// the input stays stalled until that result has been taken.
// The hash mode is written through cfg_valid_i / cfg_ready_o; ready is high
// only while the block is idle.
// One command is worked at a time; the next can be taken in the cycle after
// the result transfer. A read or a bad key gives its result without hashing.
// An insert hashes the key: division and multiplicative modes take one
// remainder, folding sums the decimal digits one per cycle, and mid-square
// squares, counts the digits and then selects one, one cycle per step. An
// occupied home then probes one slot per cycle for a free one, hashes the
// resident key and walks one link per cycle, at most ten.
// After reset the table is empty, all links are none and the mode is
// division; no clearing pass is needed.
module chained_hash_insert_with_replacement (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  chi_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output chi_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);
  import chi_pkg::*;

  logic [1:0] mode_q;
  ctrl_t      ctrl;
  stat_t      stat;

  // Mode register, written only while no command is in flight.
  assign cfg_ready_o = !in_stall_o;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= HASH_DIV;
    else if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
  end

  chi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  chi_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .item_i (in_item_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .res_o  (out_item_o)
  );

endmodule
